/* hdl/sha_pkg.sv */
// Shared types, constants and round functions for the SHA-256 byte-stream engine.
package sha_pkg;

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_ABSORB = 2'd1,
    CMD_FINISH = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t       op;
    logic [7:0] data;
  } entry_t;

  localparam int QueueDepth = 4;

  function automatic logic [31:0] init_hash(input logic [2:0] idx);
    logic [31:0] v;
    case (idx)
      3'd0: v = 32'h6a09e667;
      3'd1: v = 32'hbb67ae85;
      3'd2: v = 32'h3c6ef372;
      3'd3: v = 32'ha54ff53a;
      3'd4: v = 32'h510e527f;
      3'd5: v = 32'h9b05688c;
      3'd6: v = 32'h1f83d9ab;
      default: v = 32'h5be0cd19;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return k[idx];
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] v, input int s);
    return (v >> s) | (v << (32 - s));
  endfunction

endpackage

/* hdl/sha256_hash_stream.sv */
// Top level of the byte-stream SHA-256 engine.
// Start and absorb beats are taken while the core is idle, until the block buffer
// fills; then a 64-byte block is loaded word by word and run through 64 rounds,
// one round per cycle in a single shared round unit. Finish pads byte by byte up to
// the block end, compresses one or two blocks, then emits eight digest beats.
// A four-entry command queue lets the input run ahead while the core is busy.
module sha256_hash_stream
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  logic   q_valid;
  entry_t q_entry;
  logic   q_take;

  sha_front u_front (
    .clk, .rst, .in_valid, .in_stall,
    .in_op(cmd_t'(command)), .in_data(data_byte),
    .q_valid, .q_entry, .q_take
  );

  sha_core u_core (
    .clk, .rst, .q_valid, .q_entry, .q_take,
    .out_valid, .out_stall, .digest_word, .word_index, .last_word
  );

`ifndef SYNTHESIS
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_word == (word_index == 3'd7)))
    else $error("last flag does not match word index");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(word_index))
    else $error("stalled beat changed");
`endif

endmodule

/* hdl/sha_front.sv */
// Input stage and command queue between the input port and the hash core.
module sha_front
  import sha_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  cmd_t       in_op,
  input  logic [7:0] in_data,
  output logic       q_valid,
  output entry_t     q_entry,
  input  logic       q_take
);

  localparam int Aw = $clog2(QueueDepth);

  entry_t       mem [QueueDepth];
  logic [Aw-1:0] wr_ptr;
  logic [Aw-1:0] rd_ptr;
  logic [Aw:0]   count;
  logic          push;
  logic          pop;

  // Unused command codes are dropped here and never reach the core.
  assign in_stall = (count == Aw'(0) + (Aw+1)'(QueueDepth));
  assign push     = in_valid && !in_stall && (in_op != CMD_NONE);
  assign q_valid  = (count != '0);
  assign q_entry  = mem[rd_ptr];
  assign pop      = q_valid && q_take;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= '{op: in_op, data: in_data};
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (Aw+1)'(push) - (Aw+1)'(pop);
    end
  end

endmodule

/* hdl/sha_core.sv */
// Block buffer, padding sequencer, round engine and digest output register.
module sha_core
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  entry_t      q_entry,
  output logic        q_take,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_PAD   = 5'b00010,
    S_LOAD  = 5'b00100,
    S_ROUND = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t       state;
  logic         finishing;
  logic         pad_tail;
  logic         len_written;
  logic [31:0]  buf_mem [16];
  logic [5:0]   fill;
  logic [60:0]  byte_count;
  logic [63:0]  bit_len;
  logic [31:0]  hw [8];
  logic [31:0]  va, vb, vc, vd, ve, vf, vg, vh;
  logic [31:0]  w [16];
  logic [5:0]   rnd;
  logic [4:0]   ld;
  logic [2:0]   emit_idx;
  logic [7:0]   pad_byte;
  logic         wr_en;
  logic [7:0]   wr_byte;
  logic [31:0]  rd_word;
  logic [31:0]  wt, t1, t2, s0, s1, w_next;

  assign q_take = (state == S_IDLE);

  // The length goes into the last eight bytes only when the 0x80 marker fit before them.
  always_comb begin
    if (!finishing) begin
      pad_byte = 8'h80;
    end else if (fill < 6'd56 || pad_tail) begin
      pad_byte = 8'h00;
    end else begin
      pad_byte = bit_len[{~fill[2:0], 3'b111} -: 8];
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_byte = q_entry.data;
    if (state == S_IDLE && q_valid && q_entry.op == CMD_ABSORB) begin
      wr_en = 1'b1;
    end else if (state == S_PAD) begin
      wr_en   = 1'b1;
      wr_byte = pad_byte;
    end
  end

  assign wt = w[0];
  assign s0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
  assign s1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
  assign w_next = w[0] + s0 + w[9] + s1;
  assign t1 = vh + (rotr(ve, 6) ^ rotr(ve, 11) ^ rotr(ve, 25)) + ((ve & vf) ^ (~ve & vg))
              + round_k(rnd) + wt;
  assign t2 = (rotr(va, 2) ^ rotr(va, 13) ^ rotr(va, 22)) + ((va & vb) ^ (va & vc) ^ (vb & vc));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      buf_mem[fill[5:2]][{~fill[1:0], 3'b000} +: 8] <= wr_byte;
    end
    rd_word <= buf_mem[ld[3:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      finishing  <= 1'b0;
      pad_tail   <= 1'b0;
      fill       <= '0;
      byte_count <= '0;
      out_valid  <= 1'b0;
      for (int i = 0; i < 8; i++) hw[i] <= init_hash(3'(i));
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            case (q_entry.op)
              CMD_START: begin
                fill       <= '0;
                byte_count <= '0;
                for (int i = 0; i < 8; i++) hw[i] <= init_hash(3'(i));
              end
              CMD_ABSORB: begin
                byte_count <= byte_count + 61'd1;
                fill       <= fill + 6'd1;
                if (fill == 6'd63) begin
                  state <= S_LOAD;
                  ld    <= '0;
                end
              end
              CMD_FINISH: begin
                bit_len <= {byte_count, 3'b000};
                state   <= S_PAD;
              end
              default: ;
            endcase
          end
        end
        S_PAD: begin
          finishing <= 1'b1;
          if (!finishing) begin
            pad_tail <= (fill >= 6'd56);
          end
          fill      <= fill + 6'd1;
          if (fill == 6'd63) begin
            state <= S_LOAD;
            ld    <= '0;
          end
        end
        S_LOAD: begin
          // The buffer read is registered: word ld-1 arrives while ld is issued.
          ld <= ld + 5'd1;
          if (ld != 5'd0) begin
            for (int i = 0; i < 15; i++) w[i] <= w[i+1];
            w[15] <= rd_word;
          end
          if (ld == 5'd16) begin
            state <= S_ROUND;
            rnd   <= '0;
            va <= hw[0]; vb <= hw[1]; vc <= hw[2]; vd <= hw[3];
            ve <= hw[4]; vf <= hw[5]; vg <= hw[6]; vh <= hw[7];
          end
        end
        S_ROUND: begin
          for (int i = 0; i < 15; i++) w[i] <= w[i+1];
          w[15] <= w_next;
          vh <= vg; vg <= vf; vf <= ve; ve <= vd + t1;
          vd <= vc; vc <= vb; vb <= va; va <= t1 + t2;
          rnd <= rnd + 6'd1;
          if (rnd == 6'd63) begin
            hw[0] <= hw[0] + t1 + t2; hw[1] <= hw[1] + va;
            hw[2] <= hw[2] + vb;      hw[3] <= hw[3] + vc;
            hw[4] <= hw[4] + vd + t1; hw[5] <= hw[5] + ve;
            hw[6] <= hw[6] + vf;      hw[7] <= hw[7] + vg;
            pad_tail <= 1'b0;
            if (!finishing) begin
              state <= S_IDLE;
            end else if (len_written) begin
              state    <= S_EMIT;
              emit_idx <= '0;
            end else begin
              state <= S_PAD;
            end
          end
        end
        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_valid   <= 1'b1;
            digest_word <= hw[emit_idx];
            word_index  <= emit_idx;
            last_word   <= (emit_idx == 3'd7);
            emit_idx    <= emit_idx + 3'd1;
            if (emit_idx == 3'd7) begin
              state      <= S_IDLE;
              finishing  <= 1'b0;
              fill       <= '0;
              byte_count <= '0;
              for (int i = 0; i < 8; i++) hw[i] <= init_hash(3'(i));
            end
          end
        end
        default: state <= S_IDLE;
      endcase
      if (out_valid && !out_stall && !(state == S_EMIT)) begin
        out_valid <= 1'b0;
      end
    end
  end

  // The flag marks a padded block that carries the message length in its last bytes.
  always_ff @(posedge clk) begin
    if (rst) begin
      len_written <= 1'b0;
    end else if (state == S_PAD && fill == 6'd63 && finishing && !pad_tail) begin
      len_written <= 1'b1;
    end else if (state == S_EMIT) begin
      len_written <= 1'b0;
    end
  end

endmodule
